/* rtl/core/rkvr_pkg.sv */
// Shared types and constants for the radial kernel volume resampler.
// Holds the request and response beat formats, command codes and CSR indexes.
// No dependencies.
`default_nettype none

package rkvr_pkg;

   // command codes
   localparam logic [1:0] CMD_TABLE   = 2'd0;
   localparam logic [1:0] CMD_VOXEL   = 2'd1;
   localparam logic [1:0] CMD_COMPUTE = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   // CSR indexes
   localparam logic [2:0] CSR_SIZE_X  = 3'd0;
   localparam logic [2:0] CSR_SIZE_Y  = 3'd1;
   localparam logic [2:0] CSR_SIZE_Z  = 3'd2;
   localparam logic [2:0] CSR_SCALE   = 3'd3;
   localparam logic [2:0] CSR_SUPPORT = 3'd4;
   localparam logic [2:0] CSR_TCOUNT  = 3'd5;

   localparam int CSR_IW   = 3;
   localparam int CSR_DW   = 24;
   localparam int SIZE_W   = 6;
   localparam int SCALE_W  = 12;
   localparam int SUPP_W   = 24;
   localparam int TCOUNT_W = 11;
   localparam int SAMPLE_W = 32;
   localparam int FRAC_W   = 16;

   // distance clamp, 2^24 in Q.16
   localparam logic [24:0] DIST_CLAMP = 25'h100_0000;

   typedef struct packed {
      logic [1:0]                  command;
      logic [9:0]                  table_index;
      logic [14:0]                 voxel_index;
      logic signed [SAMPLE_W-1:0]  sample_value;
      logic [7:0]                  out_x;
      logic [7:0]                  out_y;
      logic [7:0]                  out_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0]  voxel_value;
      logic                        saturated;
      logic                        range_error;
   } rsp_payload_type;

endpackage

`default_nettype wire

/* rtl/core/rkvr_div.sv */
// Serial restoring divider, one quotient bit per cycle.
// Used for the per-axis scale division and the table position division.
// Depends on nothing; widths come from parameters.
`default_nettype none

module rkvr_div #(
   parameter int DW = 52,
   parameter int VW = 24,
   parameter int QW = 31
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [DW-1:0] dividend,
   input  wire logic [VW-1:0] divisor,
   output logic               busy,
   output logic               done,
   output logic [QW-1:0]      quotient
);

   localparam int CW = (QW > 1) ? $clog2(QW) : 1;

   logic [VW-1:0] rem_ff;
   logic [VW-1:0] dvs_ff;
   logic [QW-1:0] num_ff;
   logic [CW-1:0] cnt_ff;
   logic          busy_ff;
   logic          done_ff;

   logic [VW:0]   trial;
   logic          ge;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, num_ff[QW-1]};
      ge    = trial >= {1'b0, dvs_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            // top bits are known to sit below the divisor
            rem_ff  <= VW'(dividend >> QW);
            num_ff  <= dividend[QW-1:0];
            dvs_ff  <= divisor;
            cnt_ff  <= CW'(QW - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? VW'(trial - {1'b0, dvs_ff}) : VW'(trial);
            num_ff <= {num_ff[QW-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

/* rtl/core/rkvr_sqrt.sv */
// Serial integer square root, one root bit per cycle.
// Gives floor(sqrt(operand)) for the radial distance.
// Depends on nothing; widths come from parameters.
`default_nettype none

module rkvr_sqrt #(
   parameter int RW = 24
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [2*RW-1:0] operand,
   output logic                 done,
   output logic [RW-1:0]        root
);

   localparam int CW = (RW > 1) ? $clog2(RW) : 1;

   logic [2*RW-1:0] val_ff;
   logic [RW+1:0]   rem_ff;
   logic [RW-1:0]   root_ff;
   logic [CW-1:0]   cnt_ff;
   logic            busy_ff;
   logic            done_ff;

   logic [RW+3:0]   rem2;
   logic [RW+3:0]   trial;
   logic            ge;

   // bring down two operand bits, try root*4+1
   always_comb begin
      rem2  = {rem_ff, val_ff[2*RW-1 -: 2]};
      trial = (RW+4)'({root_ff, 2'b01});
      ge    = rem2 >= trial;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            val_ff  <= operand;
            rem_ff  <= '0;
            root_ff <= '0;
            cnt_ff  <= CW'(RW - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            val_ff  <= {val_ff[2*RW-3:0], 2'b00};
            rem_ff  <= ge ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
            root_ff <= {root_ff[RW-2:0], ge};
            cnt_ff  <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

/* rtl/core/radial_kernel_volume_resample.sv */
// A compute beat first divides the centred offset of each axis by the scale on the serial
// divider (Q = divider quotient bits, 31 by default), then walks every source voxel; one
// outside the support adds nothing, one inside runs the serial square root (24 steps) and
// the serial divider (Q steps) for its table position. One beat is in work at a time.
// Synchronous active-high reset clears control and sets the CSRs to their defaults; the
// table and volume memories are not cleared and read as undefined until written.
`default_nettype none

module radial_kernel_volume_resample #(
   parameter int MAX_SRC_DIM = 32,
   parameter int TABLE_DEPTH = 1024,
   parameter int MAX_OUT_DIM = 256
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire rkvr_pkg::req_payload_type     req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output rkvr_pkg::rsp_payload_type          rsp_data,
   input  wire logic                          csr_we,
   input  wire logic [rkvr_pkg::CSR_IW-1:0]   csr_index,
   input  wire logic [rkvr_pkg::CSR_DW-1:0]   csr_wdata
);

   localparam int SDW       = $clog2(MAX_SRC_DIM + 1);
   localparam int XW        = $clog2(MAX_SRC_DIM);
   localparam int VOL_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int VAW       = $clog2(VOL_DEPTH);
   localparam int TAW       = $clog2(TABLE_DEPTH);
   localparam int NW        = $clog2(MAX_OUT_DIM + 1);
   localparam int MW        = $clog2(MAX_OUT_DIM);
   localparam int AQW       = MW + 23;
   localparam int TQW       = TAW + 16;
   localparam int DIV_QW    = (AQW > TQW) ? AQW : TQW;
   localparam int TDW       = rkvr_pkg::SUPP_W + TAW + 16;
   localparam int DIV_DW    = (DIV_QW > TDW) ? DIV_QW : TDW;
   localparam int DW        = ((DIV_QW + 1 > SDW + 17) ? DIV_QW + 1 : SDW + 17) + 1;
   localparam int AW        = ((NW > 9) ? NW : 9) + 1;
   localparam int NPW       = SDW + rkvr_pkg::SCALE_W + 1;
   localparam int RW        = rkvr_pkg::SUPP_W;
   localparam int SQW       = 50;
   localparam int PW        = 50;

   typedef enum logic [3:0] {
      ST_IDLE, ST_AXIS, ST_AXIS_W, ST_DIST, ST_SQ, ST_CMP, ST_ROOT, ST_SCALE,
      ST_DIVS, ST_DIVW, ST_TRD, ST_INTERP, ST_WSUM, ST_PROD, ST_ACC, ST_NEXT
   } state_type;

   // ---------------------------------------------------------------- CSRs
   logic [rkvr_pkg::SIZE_W-1:0]   size_ff [3];
   logic [rkvr_pkg::SCALE_W-1:0]  scale_ff;
   logic [rkvr_pkg::SUPP_W-1:0]   supp_ff;
   logic [rkvr_pkg::TCOUNT_W-1:0] tcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff[0] <= 6'd32;
         size_ff[1] <= 6'd32;
         size_ff[2] <= 6'd32;
         scale_ff   <= 12'd256;
         supp_ff    <= 24'd131072;
         tcount_ff  <= 11'd1024;
      end else if (csr_we) begin
         case (csr_index)
            rkvr_pkg::CSR_SIZE_X:  size_ff[0] <= csr_wdata[rkvr_pkg::SIZE_W-1:0];
            rkvr_pkg::CSR_SIZE_Y:  size_ff[1] <= csr_wdata[rkvr_pkg::SIZE_W-1:0];
            rkvr_pkg::CSR_SIZE_Z:  size_ff[2] <= csr_wdata[rkvr_pkg::SIZE_W-1:0];
            rkvr_pkg::CSR_SCALE:   scale_ff   <= csr_wdata[rkvr_pkg::SCALE_W-1:0];
            rkvr_pkg::CSR_SUPPORT: supp_ff    <= csr_wdata[rkvr_pkg::SUPP_W-1:0];
            rkvr_pkg::CSR_TCOUNT:  tcount_ff  <= csr_wdata[rkvr_pkg::TCOUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // --------------------------------------------------------- state regs
   state_type                      state_ff;
   logic [1:0]                     axis_ff;
   logic [7:0]                     o_ff [3];
   logic signed [DIV_QW:0]         qs_ff [3];
   logic [XW-1:0]                  pos_ff [3];
   logic [VAW-1:0]                 vaddr_ff;
   logic [24:0]                    d_ff [3];
   logic [SQW-1:0]                 sq_ff [3];
   logic [2*rkvr_pkg::SUPP_W-1:0]  supp_sq_ff;
   logic [RW-1:0]                  root_ff;
   logic [RW+TAW-1:0]              rc_ff;
   logic [DIV_QW-1:0]              t_ff;
   logic                           last_ff;
   logic [15:0]                    f_ff;
   logic signed [PW-1:0]           p0_ff;
   logic signed [PW-1:0]           p1_ff;
   logic signed [31:0]             w_ff;
   logic signed [63:0]             prod_ff;
   logic signed [63:0]             sum_ff;
   logic                           rng_ff;
   logic                           fin_ff;
   logic                           rsp_valid_ff;
   rkvr_pkg::rsp_payload_type      rsp_data_ff;

   // ------------------------------------------------- effective settings
   logic [SDW-1:0]                 m_w [3];
   logic [NW-1:0]                  n_w [3];
   logic [rkvr_pkg::SCALE_W-1:0]   sc_w;
   logic [rkvr_pkg::SUPP_W-1:0]    supp_w;
   logic [TAW-1:0]                 cm1_w;
   logic [AW-1:0]                  mag_w [3];
   logic                           neg_w [3];
   logic [24:0]                    dist_w [3];
   logic                           range_bad;

   logic [NPW-1:0]                 np;
   logic [NPW-1:0]                 nq;
   logic [AW-1:0]                  two_o1;
   logic [AW-1:0]                  nn;
   logic signed [DW-1:0]           soff;
   logic signed [DW-1:0]           dd;
   logic [DW-1:0]                  ad;

   always_comb begin
      sc_w   = (scale_ff == '0) ? rkvr_pkg::SCALE_W'(1) : scale_ff;
      supp_w = (supp_ff == '0) ? rkvr_pkg::SUPP_W'(1) : supp_ff;
      if (32'(tcount_ff) < 32'd2)
         cm1_w = TAW'(1);
      else if (32'(tcount_ff) > TABLE_DEPTH)
         cm1_w = TAW'(TABLE_DEPTH - 1);
      else
         cm1_w = TAW'(tcount_ff - 1'b1);
      range_bad = 1'b0;
      for (int k = 0; k < 3; k++) begin
         // source extent and output extent ceil(m * scale / 256), capped at MAX_OUT_DIM
         if (size_ff[k] == '0)
            m_w[k] = SDW'(1);
         else if (32'(size_ff[k]) > MAX_SRC_DIM)
            m_w[k] = SDW'(MAX_SRC_DIM);
         else
            m_w[k] = SDW'(size_ff[k]);
         np = NPW'(m_w[k]) * NPW'(sc_w) + NPW'(255);
         nq = np >> 8;
         n_w[k] = (32'(nq) > MAX_OUT_DIM) ? NW'(MAX_OUT_DIM) : NW'(nq);
         if (32'(o_ff[k]) >= 32'(n_w[k]))
            range_bad = 1'b1;
         // centred output offset 2o - N + 1
         two_o1   = AW'({o_ff[k], 1'b1});
         nn       = AW'(n_w[k]);
         neg_w[k] = two_o1 < nn;
         mag_w[k] = neg_w[k] ? (nn - two_o1) : (two_o1 - nn);
         // distance along this axis, Q.16, clamped
         soff = $signed(DW'({pos_ff[k], 1'b1})) - $signed(DW'(m_w[k]));
         dd   = DW'(qs_ff[k]) - (soff <<< 15);
         ad   = dd[DW-1] ? DW'(-dd) : DW'(dd);
         dist_w[k] = (ad > DW'(rkvr_pkg::DIST_CLAMP)) ? rkvr_pkg::DIST_CLAMP : 25'(ad);
      end
   end

   // ------------------------------------------------------------- memories
   logic [31:0]    tbl_mem [TABLE_DEPTH];
   logic [31:0]    vol_mem [VOL_DEPTH];
   logic [31:0]    tbl_q0_ff;
   logic [31:0]    tbl_q1_ff;
   logic [31:0]    vol_q_ff;

   logic           req_acc;
   logic [31:0]    tidx_w;
   logic [31:0]    vidx_w;
   logic [TAW-1:0] idx_lo;
   logic [DIV_QW-17:0] idx_hi;
   logic           tbl_last;
   logic [TAW-1:0] tbl_a0;
   logic [TAW-1:0] tbl_a1;

   assign req_acc = req_valid && !req_stall;
   assign tidx_w  = 32'(req_data.table_index);
   assign vidx_w  = 32'(req_data.voxel_index);

   // table position split into index and fraction
   always_comb begin
      idx_hi   = t_ff[DIV_QW-1:16];
      idx_lo   = TAW'(idx_hi);
      tbl_last = idx_hi >= (DIV_QW-16)'(cm1_w);
      tbl_a0   = tbl_last ? cm1_w : idx_lo;
      tbl_a1   = TAW'(idx_lo + 1'b1);
   end

   // kernel table: one write port, two read ports
   always_ff @(posedge clock) begin
      if (req_acc && req_data.command == rkvr_pkg::CMD_TABLE && tidx_w < TABLE_DEPTH)
         tbl_mem[tidx_w[TAW-1:0]] <= req_data.sample_value;
      if (state_ff == ST_TRD) begin
         tbl_q0_ff <= tbl_mem[tbl_a0];
         tbl_q1_ff <= tbl_mem[tbl_a1];
      end
   end

   // source volume: one write port, one read port
   always_ff @(posedge clock) begin
      if (req_acc && req_data.command == rkvr_pkg::CMD_VOXEL && vidx_w < VOL_DEPTH)
         vol_mem[vidx_w[VAW-1:0]] <= req_data.sample_value;
      if (state_ff == ST_DIST)
         vol_q_ff <= vol_mem[vaddr_ff];
   end

   // ------------------------------------------------------- shared units
   logic                div_start;
   logic [DIV_DW-1:0]   div_dividend;
   logic [RW-1:0]       div_divisor;
   logic                div_busy;
   logic                div_done;
   logic [DIV_QW-1:0]   div_q;

   // no axis division for an out-of-range beat
   assign div_start    = ((state_ff == ST_AXIS) && !range_bad) || (state_ff == ST_DIVS);
   assign div_dividend = (state_ff == ST_AXIS) ? (DIV_DW'(mag_w[axis_ff]) << 23)
                                               : DIV_DW'({rc_ff, 16'h0000});
   assign div_divisor  = (state_ff == ST_AXIS) ? RW'(sc_w) : supp_w;

   rkvr_div #(
      .DW (DIV_DW),
      .VW (RW),
      .QW (DIV_QW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_q)
   );

   logic [SQW+1:0]   d2_w;
   logic             far_w;
   logic             sq_start;
   logic [2*RW-1:0]  sq_operand;
   logic             sq_done;
   logic [RW-1:0]    sq_root;

   assign d2_w       = (SQW+2)'(sq_ff[0]) + (SQW+2)'(sq_ff[1]) + (SQW+2)'(sq_ff[2]);
   assign far_w      = d2_w > (SQW+2)'(supp_sq_ff);
   assign sq_start   = (state_ff == ST_CMP) && !far_w;
   assign sq_operand = (2*RW)'(d2_w);

   rkvr_sqrt #(
      .RW (RW)
   ) u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sq_start),
      .operand (sq_operand),
      .done    (sq_done),
      .root    (sq_root)
   );

   // ------------------------------------------------------------ sequencer
   logic signed [PW:0]  wsum_w;
   logic                last_vox;
   logic signed [63:0]  sat_hi;
   logic signed [63:0]  sat_lo;
   logic                rsp_load;

   assign wsum_w   = (PW+1)'(p0_ff) + (PW+1)'(p1_ff);
   assign last_vox = (pos_ff[0] == XW'(m_w[0] - 1'b1)) && (pos_ff[1] == XW'(m_w[1] - 1'b1))
                     && (pos_ff[2] == XW'(m_w[2] - 1'b1));
   assign sat_hi   = 64'sh0000_0000_7FFF_FFFF;
   assign sat_lo   = -64'sh0000_0000_8000_0000;
   // finished result moves into the output register
   assign rsp_load = (state_ff == ST_IDLE) && fin_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         fin_ff       <= 1'b0;
         axis_ff      <= '0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && !rsp_load)
            rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               // result waits here until the output register is free
               if (rsp_load) begin
                  fin_ff       <= 1'b0;
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff.range_error <= rng_ff;
                  if (rng_ff) begin
                     rsp_data_ff.voxel_value <= '0;
                     rsp_data_ff.saturated   <= 1'b0;
                  end else if (sum_ff > sat_hi) begin
                     rsp_data_ff.voxel_value <= 32'sh7FFF_FFFF;
                     rsp_data_ff.saturated   <= 1'b1;
                  end else if (sum_ff < sat_lo) begin
                     rsp_data_ff.voxel_value <= -32'sh8000_0000;
                     rsp_data_ff.saturated   <= 1'b1;
                  end else begin
                     rsp_data_ff.voxel_value <= 32'(sum_ff);
                     rsp_data_ff.saturated   <= 1'b0;
                  end
               end else if (req_acc && req_data.command == rkvr_pkg::CMD_COMPUTE) begin
                  o_ff[0]    <= req_data.out_x;
                  o_ff[1]    <= req_data.out_y;
                  o_ff[2]    <= req_data.out_z;
                  sum_ff     <= '0;
                  supp_sq_ff <= supp_w * supp_w;
                  axis_ff    <= '0;
                  state_ff   <= ST_AXIS;
               end
            end
            ST_AXIS: begin
               // range check uses the coordinates latched when the beat was accepted
               if (range_bad) begin
                  rng_ff   <= 1'b1;
                  fin_ff   <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  rng_ff   <= 1'b0;
                  state_ff <= ST_AXIS_W;
               end
            end
            ST_AXIS_W: begin
               if (div_done) begin
                  qs_ff[axis_ff] <= neg_w[axis_ff] ? -$signed({1'b0, div_q})
                                                   : $signed({1'b0, div_q});
                  if (axis_ff == 2'd2) begin
                     pos_ff[0] <= '0;
                     pos_ff[1] <= '0;
                     pos_ff[2] <= '0;
                     vaddr_ff  <= '0;
                     state_ff  <= ST_DIST;
                  end else begin
                     axis_ff  <= axis_ff + 1'b1;
                     state_ff <= ST_AXIS;
                  end
               end
            end
            ST_DIST: begin
               d_ff[0]  <= dist_w[0];
               d_ff[1]  <= dist_w[1];
               d_ff[2]  <= dist_w[2];
               state_ff <= ST_SQ;
            end
            ST_SQ: begin
               sq_ff[0] <= SQW'(d_ff[0]) * SQW'(d_ff[0]);
               sq_ff[1] <= SQW'(d_ff[1]) * SQW'(d_ff[1]);
               sq_ff[2] <= SQW'(d_ff[2]) * SQW'(d_ff[2]);
               state_ff <= ST_CMP;
            end
            ST_CMP: begin
               // beyond support: weight is zero, nothing to add
               state_ff <= far_w ? ST_NEXT : ST_ROOT;
            end
            ST_ROOT: begin
               if (sq_done) begin
                  root_ff  <= sq_root;
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               rc_ff    <= (RW+TAW)'(root_ff) * (RW+TAW)'(cm1_w);
               state_ff <= ST_DIVS;
            end
            ST_DIVS: begin
               state_ff <= ST_DIVW;
            end
            ST_DIVW: begin
               if (div_done) begin
                  t_ff     <= div_q;
                  state_ff <= ST_TRD;
               end
            end
            ST_TRD: begin
               last_ff  <= tbl_last;
               f_ff     <= t_ff[15:0];
               state_ff <= ST_INTERP;
            end
            ST_INTERP: begin
               p0_ff    <= $signed(tbl_q0_ff) * $signed({1'b0, 17'(17'h10000 - {1'b0, f_ff})});
               p1_ff    <= $signed(tbl_q1_ff) * $signed({2'b00, f_ff});
               state_ff <= ST_WSUM;
            end
            ST_WSUM: begin
               w_ff     <= last_ff ? $signed(tbl_q0_ff) : $signed(wsum_w[47:16]);
               state_ff <= ST_PROD;
            end
            ST_PROD: begin
               prod_ff  <= $signed(vol_q_ff) * w_ff;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               sum_ff   <= sum_ff + (prod_ff >>> 16);
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               // x fastest, then y, then z; linear address follows
               vaddr_ff <= vaddr_ff + 1'b1;
               if (last_vox) begin
                  fin_ff   <= 1'b1;
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIST;
                  if (pos_ff[0] == XW'(m_w[0] - 1'b1)) begin
                     pos_ff[0] <= '0;
                     if (pos_ff[1] == XW'(m_w[1] - 1'b1)) begin
                        pos_ff[1] <= '0;
                        pos_ff[2] <= pos_ff[2] + 1'b1;
                     end else begin
                        pos_ff[1] <= pos_ff[1] + 1'b1;
                     end
                  end else begin
                     pos_ff[0] <= pos_ff[0] + 1'b1;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // busy whenever an item is in work or its result is still held back
   assign req_stall = (state_ff != ST_IDLE) || fin_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("divider restarted while busy");

   a_root_in_support: assert property (@(posedge clock) disable iff (reset)
      sq_start |-> (sq_operand <= supp_sq_ff))
      else $error("square root started outside support");

   a_interp_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRD) && !tbl_last |-> (tbl_a1 <= cm1_w))
      else $error("interpolation reads past the table in use");

   a_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.range_error |->
         (rsp_data_ff.voxel_value == '0) && !rsp_data_ff.saturated)
      else $error("range error beat carries a value");
`endif

endmodule

`default_nettype wire

/* verif/radial_kernel_volume_resample_tb.sv */
// Self-checking testbench for the radial kernel volume resampler.
// Predicts each result from its own copy of table, volume and CSRs; uses rkvr_pkg.
`timescale 1ns / 1ps

module radial_kernel_volume_resample_tb;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int TABLE_FILL     = 8;
   localparam int VOLUME_FILL    = 32;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   rkvr_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rkvr_pkg::rsp_payload_type rsp_data;
   logic                      csr_we = 1'b0;
   logic [rkvr_pkg::CSR_IW-1:0] csr_index = '0;
   logic [rkvr_pkg::CSR_DW-1:0] csr_wdata = '0;

   radial_kernel_volume_resample dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_we, .csr_index, .csr_wdata
   );

   // predictor state
   logic signed [31:0] kernel_words [1024];
   logic signed [31:0] volume_words [32768];
   logic [23:0]        csr_shadow [6];

   rkvr_pkg::req_payload_type pending_beats [$];
   rkvr_pkg::rsp_payload_type voxel_expect [$];
   int  error_count = 0;
   int  idle_cycles = 0;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   bit  req_taken = 1'b0;

   initial forever #5 clock = ~clock;

   task automatic report_mismatch(input string what, input longint want, input longint got);
      $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $realtime);
      error_count++;
   endtask

   function automatic longint clamp_val(input longint v, input longint lo, input longint hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic longint src_dim(input int axis);
      return clamp_val(longint'(csr_shadow[axis]), 1, 32);
   endfunction

   function automatic longint scale_now();
      return clamp_val(longint'(csr_shadow[rkvr_pkg::CSR_SCALE]), 1, 4095);
   endfunction

   function automatic longint out_dim(input int axis);
      return clamp_val((src_dim(axis) * scale_now() + 255) / 256, 1, 256);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // clamped absolute offset along one axis, Q.16
   function automatic longint axis_gap(input longint o, input longint n, input longint s,
                                       input longint m, input longint sc);
      longint a, mag, q, d;
      a = 2 * o - n + 1;
      mag = (a < 0) ? -a : a;
      q = (mag << 23) / sc;
      d = ((a < 0) ? -q : q) - (2 * s - m + 1) * 32768;
      if (d < 0) d = -d;
      if (d > 64'd16777216) d = 64'd16777216;
      return d;
   endfunction

   function automatic longint kernel_at(input longint d2);
      longint supp, cnt, r, t, i, f;
      supp = clamp_val(longint'(csr_shadow[rkvr_pkg::CSR_SUPPORT]), 1, 16777215);
      cnt  = clamp_val(longint'(csr_shadow[rkvr_pkg::CSR_TCOUNT]), 2, 1024);
      if (d2 > supp * supp) return 0;
      r = longint'(int_sqrt(d2));
      t = (r * (cnt - 1) * 65536) / supp;
      i = t >> 16;
      f = t & 64'hFFFF;
      if (i >= cnt - 1) return longint'(kernel_words[cnt - 1]);
      return (longint'(kernel_words[i]) * (65536 - f) + longint'(kernel_words[i + 1]) * f) >>> 16;
   endfunction

   function automatic rkvr_pkg::rsp_payload_type resample_voxel(
         input rkvr_pkg::req_payload_type beat);
      rkvr_pkg::rsp_payload_type r;
      longint m [3];
      longint n [3];
      longint o [3];
      longint sc, sum, w, dz, dy, dx, addr;
      r = '0;
      sc = scale_now();
      o[0] = beat.out_x; o[1] = beat.out_y; o[2] = beat.out_z;
      for (int a = 0; a < 3; a++) begin
         m[a] = src_dim(a);
         n[a] = out_dim(a);
         if (o[a] >= n[a]) begin
            r.range_error = 1'b1;
            return r;
         end
      end
      sum = 0;
      for (longint z = 0; z < m[2]; z++) begin
         dz = axis_gap(o[2], n[2], z, m[2], sc);
         for (longint y = 0; y < m[1]; y++) begin
            dy = axis_gap(o[1], n[1], y, m[1], sc);
            for (longint x = 0; x < m[0]; x++) begin
               dx = axis_gap(o[0], n[0], x, m[0], sc);
               w = kernel_at(dx * dx + dy * dy + dz * dz);
               addr = x + m[0] * (y + m[1] * z);
               if (w != 0) sum += (longint'(volume_words[addr]) * w) >>> 16;
            end
         end
      end
      if (sum > 64'sd2147483647) begin
         sum = 64'sd2147483647; r.saturated = 1'b1;
      end else if (sum < -64'sd2147483648) begin
         sum = -64'sd2147483648; r.saturated = 1'b1;
      end
      r.voxel_value = sum[31:0];
      return r;
   endfunction

   // accepted beats update the predictor; results checked in order
   always @(posedge clock) begin
      req_taken = req_valid && !req_stall;
      if (!reset) begin
         if (req_taken) begin
            case (req_data.command)
               rkvr_pkg::CMD_TABLE:   kernel_words[req_data.table_index] = req_data.sample_value;
               rkvr_pkg::CMD_VOXEL:   volume_words[req_data.voxel_index] = req_data.sample_value;
               rkvr_pkg::CMD_COMPUTE: voxel_expect.push_back(resample_voxel(req_data));
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (voxel_expect.size() == 0) begin
               report_mismatch("unexpected beat", 0, 1);
            end else begin
               rkvr_pkg::rsp_payload_type want;
               want = voxel_expect.pop_front();
               if (rsp_data.voxel_value !== want.voxel_value)
                  report_mismatch("voxel_value", want.voxel_value, rsp_data.voxel_value);
               if (rsp_data.saturated !== want.saturated)
                  report_mismatch("saturated", want.saturated, rsp_data.saturated);
               if (rsp_data.range_error !== want.range_error)
                  report_mismatch("range_error", want.range_error, rsp_data.range_error);
            end
         end
         // watchdog on cycles with no beat on either side
         if (req_taken || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired at %0t", $realtime);
            $display("[radial_kernel_volume_resample] ERROR");
            $finish;
         end
      end
   end

   // request driver and response stall, both on the falling edge
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= pending_beats.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   function automatic rkvr_pkg::req_payload_type noisy_beat(input logic [1:0] cmd);
      logic [127:0] raw;
      rkvr_pkg::req_payload_type b;
      raw = {$urandom(), $urandom(), $urandom(), $urandom()};
      b = raw[$bits(rkvr_pkg::req_payload_type)-1:0];
      b.command = cmd;
      return b;
   endfunction

   function automatic logic [31:0] pick_sample();
      if ($urandom_range(4) == 0) return $urandom();
      return 32'($urandom_range(131072)) - 32'd65536;
   endfunction

   task automatic queue_compute(input int x, input int y, input int z);
      rkvr_pkg::req_payload_type b;
      b = noisy_beat(rkvr_pkg::CMD_COMPUTE);
      b.out_x = 8'(x); b.out_y = 8'(y); b.out_z = 8'(z);
      pending_beats.push_back(b);
   endtask

   task automatic queue_write(input logic [1:0] cmd, input int idx, input logic [31:0] val);
      rkvr_pkg::req_payload_type b;
      b = noisy_beat(cmd);
      if (cmd == rkvr_pkg::CMD_TABLE) b.table_index = 10'(idx);
      else b.voxel_index = 15'(idx);
      b.sample_value = val;
      pending_beats.push_back(b);
   endtask

   task automatic queue_random(input int count);
      int r, used;
      for (int k = 0; k < count; k++) begin
         used = int'(src_dim(0) * src_dim(1) * src_dim(2));
         r = $urandom_range(99);
         if (r < 45) begin
            if ($urandom_range(9) != 0)
               queue_compute($urandom_range(int'(out_dim(0)) - 1),
                             $urandom_range(int'(out_dim(1)) - 1),
                             $urandom_range(int'(out_dim(2)) - 1));
            else
               queue_compute($urandom_range(255), $urandom_range(255), $urandom_range(255));
         end else if (r < 70) begin
            queue_write(rkvr_pkg::CMD_VOXEL, ($urandom_range(9) != 0) ? $urandom_range(used - 1)
                                             : $urandom_range(32767), pick_sample());
         end else if (r < 90) begin
            queue_write(rkvr_pkg::CMD_TABLE, $urandom_range(1023), pick_sample());
         end else begin
            pending_beats.push_back(noisy_beat(rkvr_pkg::CMD_UNUSED));
         end
      end
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || voxel_expect.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [rkvr_pkg::CSR_IW-1:0] idx, input int val);
      logic [23:0] mask;
      case (idx)
         rkvr_pkg::CSR_SCALE:   mask = 24'hFFF;
         rkvr_pkg::CSR_SUPPORT: mask = 24'hFFFFFF;
         rkvr_pkg::CSR_TCOUNT:  mask = 24'h7FF;
         default:               mask = 24'h3F;
      endcase
      @(negedge clock);
      csr_we <= 1'b1; csr_index <= idx; csr_wdata <= 24'(val);
      @(negedge clock);
      csr_we <= 1'b0;
      csr_shadow[idx] = 24'(val) & mask;
   endtask

   task automatic run_phase(input int sx, input int sy, input int sz, input int sc,
                            input int supp, input int tcnt, input int sidle, input int ridle,
                            input int count);
      write_csr(rkvr_pkg::CSR_SIZE_X, sx);
      write_csr(rkvr_pkg::CSR_SIZE_Y, sy);
      write_csr(rkvr_pkg::CSR_SIZE_Z, sz);
      write_csr(rkvr_pkg::CSR_SCALE, sc);
      write_csr(rkvr_pkg::CSR_SUPPORT, supp);
      write_csr(rkvr_pkg::CSR_TCOUNT, tcnt);
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      // corners and just outside the derived output volume
      queue_compute(0, 0, 0);
      queue_compute(int'(out_dim(0)) - 1, int'(out_dim(1)) - 1, int'(out_dim(2)) - 1);
      queue_compute(int'(out_dim(0)), 0, 0);
      queue_random(count);
      drain();
   endtask

   initial begin
      for (int i = 0; i < 1024; i++) kernel_words[i] = '0;
      for (int i = 0; i < 32768; i++) volume_words[i] = '0;
      csr_shadow = '{24'd32, 24'd32, 24'd32, 24'd256, 24'd131072, 24'd1024};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // small volume first, so no compute ever walks the full reset size
      write_csr(rkvr_pkg::CSR_SIZE_X, 1);
      write_csr(rkvr_pkg::CSR_SIZE_Y, 1);
      write_csr(rkvr_pkg::CSR_SIZE_Z, 1);

      // preload the table words and the part of the volume any phase reads
      for (int i = 0; i < TABLE_FILL; i++) queue_write(rkvr_pkg::CMD_TABLE, i, pick_sample());
      for (int i = 0; i < VOLUME_FILL; i++) queue_write(rkvr_pkg::CMD_VOXEL, i, pick_sample());
      drain();

      // directed: sample extremes, far corner writes, unknown command
      queue_write(rkvr_pkg::CMD_TABLE, 1023, 32'h7FFF_FFFF);
      queue_write(rkvr_pkg::CMD_TABLE, 0, 32'h8000_0000);
      queue_write(rkvr_pkg::CMD_VOXEL, 32767, 32'h8000_0000);
      queue_write(rkvr_pkg::CMD_VOXEL, 0, 32'h7FFF_FFFF);
      pending_beats.push_back(noisy_beat(rkvr_pkg::CMD_UNUSED));
      queue_compute(0, 0, 0);
      queue_compute(255, 255, 255);
      queue_write(rkvr_pkg::CMD_TABLE, 0, 32'h0001_0000);
      queue_write(rkvr_pkg::CMD_VOXEL, 0, 32'h0000_8000);
      drain();

      // table count never exceeds the preloaded words, volume never the preloaded voxels
      run_phase(2, 2, 2, 256, 131072, 8, 0, 0, 6);
      run_phase(32, 1, 1, 2048, 24'hFFFFFF, 2, 63, 0, 6);
      run_phase(2, 3, 4, 384, 200000, 5, 0, 63, 6);
      run_phase(1, 1, 1, 1, 1, 0, 7, 7, 5);
      run_phase(3, 3, 3, 128, 300000, 7, 7, 7, 6);
      run_phase(63, 0, 1, 0, 0, 8, 0, 0, 5);
      run_phase(3, 2, 4, 4095, 98304, 8, 0, 0, 5);

      if (error_count == 0)
         $display("[radial_kernel_volume_resample] OK");
      else
         $display("[radial_kernel_volume_resample] ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/core/rkvr_pkg.sv
rtl/core/rkvr_div.sv
rtl/core/rkvr_sqrt.sv
rtl/core/radial_kernel_volume_resample.sv
verif/radial_kernel_volume_resample_tb.sv
